### sv/mandelbrot_escape_time_pixel_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel core.
// Each macro expands to one labeled concurrent assertion, clocked by i_clk
// and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

// Same-cycle implication.
`define METP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define METP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/metp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metp_pkg
// Formats, sequencer states and saturation helpers of the escape-time core.
// ----------------------------------------------------------------------------
package metp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 31;

    localparam logic [COUNT_WIDTH-1:0] ITER_MAX_RESET = COUNT_WIDTH'(255);
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET    = LIMIT_WIDTH'(1) << (FRAC_BITS + 2);

    localparam logic CFG_ITER_MAX = 1'b0;
    localparam logic CFG_LIMIT_SQ = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0]   t_coord;
    typedef logic signed [2*COORD_WIDTH-1:0] t_prod;
    typedef logic signed [COORD_WIDTH+1:0]   t_sum;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_YY,
        S_MUL_XX,
        S_MUL_XY,
        S_UPDATE,
        S_DONE
    } t_state;

    // Saturate a shifted double-width product to the coordinate range.
    function automatic t_coord sat_prod(input t_prod v);
        logic [COORD_WIDTH:0] top;
        top = v[2*COORD_WIDTH-1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[COORD_WIDTH-1:0];
        end
        return v[2*COORD_WIDTH-1] ? COORD_MIN : COORD_MAX;
    endfunction

    // Saturate a sum with two guard bits to the coordinate range.
    function automatic t_coord sat_sum(input t_sum v);
        logic [2:0] top;
        top = v[COORD_WIDTH+1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH+1] ? COORD_MIN : COORD_MAX;
    endfunction

endpackage

### sv/mandelbrot_escape_time_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Escape-time iteration of one complex point on a single shared multiplier.
// ----------------------------------------------------------------------------
// A request carries one point c in signed Q4.28. The core iterates z <- z^2 + c
// from z = c and returns the iteration count, the escaped flag and the dot
// bit (escaped with an odd count). One 32x32 signed multiplier is shared by
// the three products of an iteration, so each iteration steps through the
// multiply states and an update state (y*y, x*x, x*y, then the update and
// escape test). The reset iteration maximum is 255. The input is stalled
// while a point is in work; a finished result waits in the output register,
// and the next request may be taken while it waits.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [metp_pkg::LIMIT_WIDTH-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [metp_pkg::COORD_WIDTH-1:0] i_c_real,
    input  logic signed [metp_pkg::COORD_WIDTH-1:0] i_c_imag,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [metp_pkg::COUNT_WIDTH-1:0]     o_iteration_count,
    output logic                                 o_escaped,
    output logic                                 o_dot
);
    import metp_pkg::*;

    t_state r_state, n_state;

    logic [COUNT_WIDTH-1:0] r_iter_max;
    logic [LIMIT_WIDTH-1:0] r_limit_sq;

    t_coord r_cr, r_ci, r_x, r_y, r_xq, r_yq;
    t_prod  r_prod;
    logic [COUNT_WIDTH-1:0] r_k;
    logic                   r_esc;

    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic                   r_out_esc;
    logic                   r_out_dot;

    // Control decoded from the state.
    logic   in_take;
    logic   out_load;
    t_coord mul_a, mul_b;

    // Update datapath.
    t_prod                  sq_shift, xy_shift;
    t_coord                 xq_now, xy2;
    t_coord                 x_next, y_next, rq;
    logic [COORD_WIDTH:0]   diff;
    logic [COORD_WIDTH:0]   rq_raw;
    logic [COUNT_WIDTH-1:0] k_next, k_max;
    logic                   esc_now, stop_now;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL_YY;
            S_MUL_YY: n_state = S_MUL_XX;
            S_MUL_XX: n_state = S_MUL_XY;
            S_MUL_XY: n_state = S_UPDATE;
            S_UPDATE: n_state = stop_now ? S_DONE : S_MUL_YY;
            S_DONE:   if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        mul_a      = r_x;
        mul_b      = r_x;
        unique case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_MUL_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            S_MUL_XX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_MUL_XY: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            S_UPDATE: ;
            S_DONE:   out_load = !r_out_valid || !i_out_stall;
            default:  ;
        endcase
    end

    assign in_take = i_in_valid && !o_in_stall;

    // ---------------- update datapath ----------------
    // Arithmetic right shift of the exact product rounds toward minus infinity.
    assign sq_shift = r_prod >>> FRAC_BITS;
    assign xy_shift = r_prod >>> (FRAC_BITS - 1);
    assign xq_now   = sat_prod(sq_shift);
    assign xy2      = sat_prod(xy_shift);

    // Both squares are non-negative, so the difference is exact in one more bit.
    assign diff   = {r_xq[COORD_WIDTH-1], r_xq} - {r_yq[COORD_WIDTH-1], r_yq};
    assign x_next = sat_sum(t_sum'({{2{r_cr[COORD_WIDTH-1]}}, r_cr})
                          + t_sum'({diff[COORD_WIDTH], diff}));
    assign y_next = sat_sum(t_sum'({{2{xy2[COORD_WIDTH-1]}}, xy2})
                          + t_sum'({{2{r_ci[COORD_WIDTH-1]}}, r_ci}));

    assign rq_raw = {1'b0, r_xq} + {1'b0, r_yq};
    assign rq     = (rq_raw[COORD_WIDTH] || rq_raw[COORD_WIDTH-1]) ? COORD_MAX
                                                                  : rq_raw[COORD_WIDTH-1:0];

    assign esc_now  = rq[LIMIT_WIDTH-1:0] >= r_limit_sq;
    assign k_next   = r_k + COUNT_WIDTH'(1);
    assign k_max    = (r_iter_max == '0) ? COUNT_WIDTH'(1) : r_iter_max;
    assign stop_now = esc_now || (k_next >= k_max);

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter_max  <= ITER_MAX_RESET;
            r_limit_sq  <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ITER_MAX: r_iter_max <= i_cfg_data[COUNT_WIDTH-1:0];
                    CFG_LIMIT_SQ: r_limit_sq <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The multiplier output is registered before the shift and saturation.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_take) begin
            r_cr <= i_c_real;
            r_ci <= i_c_imag;
            r_x  <= i_c_real;
            r_y  <= i_c_imag;
            r_k  <= '0;
        end
        if (r_state == S_MUL_XX) begin
            r_yq <= xq_now;
        end
        if (r_state == S_MUL_XY) begin
            r_xq <= xq_now;
        end
        if (r_state == S_UPDATE) begin
            r_x   <= x_next;
            r_y   <= y_next;
            r_k   <= k_next;
            r_esc <= esc_now;
        end
        if (out_load) begin
            r_out_count <= r_k;
            r_out_esc   <= r_esc;
            r_out_dot   <= r_esc && r_k[0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_escaped         = r_out_esc;
    assign o_dot             = r_out_dot;

    // ---------------- assertions ----------------
`include "mandelbrot_escape_time_pixel_core_macros.svh"

    `METP_ASSERT_NOW(a_dot_needs_escape, o_out_valid && o_dot, o_escaped && o_iteration_count[0], "dot set without an escaped odd count")
    `METP_ASSERT_NOW(a_no_escape_at_max, o_out_valid && !o_escaped, o_iteration_count == k_max, "unescaped point stopped before the iteration maximum")
    `METP_ASSERT_NEXT(a_take_starts_work, in_take, r_state == S_MUL_YY && r_k == '0, "accepted request did not start iterating")
    `METP_ASSERT_NOW(a_count_in_range, r_state == S_UPDATE, r_k < k_max, "iteration count ran past the maximum")

endmodule

### tb/sv/escape_time_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_checker
// Watches the register port and both channels of the escape-time core,
// predicts each pixel from its own copy of the registers and compares.
// ----------------------------------------------------------------------------
module escape_time_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_index,
    input  logic [metp_pkg::LIMIT_WIDTH-1:0]        i_cfg_data,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  logic signed [metp_pkg::COORD_WIDTH-1:0] i_c_real,
    input  logic signed [metp_pkg::COORD_WIDTH-1:0] i_c_imag,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic [metp_pkg::COUNT_WIDTH-1:0]        i_iteration_count,
    input  logic                                    i_escaped,
    input  logic                                    i_dot,
    output int                                      o_pending,
    output int                                      o_fail_count
);
    import metp_pkg::*;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   escaped;
        logic                   dot;
    } t_pixel;

    localparam longint COORD_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;

    logic [COUNT_WIDTH-1:0] iter_max_copy;
    logic [LIMIT_WIDTH-1:0] limit_sq_copy;
    t_pixel                 expected_pixels[$];
    t_pixel                 got;
    t_pixel                 want;
    int                     mismatches = 0;
    int                     results_seen = 0;

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI) begin
            return COORD_HI;
        end
        if (v < COORD_LO) begin
            return COORD_LO;
        end
        return v;
    endfunction

    // The arithmetic shift of the exact product rounds toward minus infinity.
    function automatic longint fixed_product(input longint a, input longint b, input int sh);
        return clamp_coord((a * b) >>> sh);
    endfunction

    function automatic t_pixel escape_time_of(input t_coord cr, input t_coord ci,
                                              input logic [COUNT_WIDTH-1:0] max_count,
                                              input logic [LIMIT_WIDTH-1:0] limit);
        longint      re;
        longint      im;
        longint      x;
        longint      y;
        longint      xq;
        longint      yq;
        longint      rq;
        longint      lim;
        int unsigned k;
        int unsigned kmax;
        logic        running;
        t_pixel      px;
        re      = cr;
        im      = ci;
        x       = re;
        y       = im;
        lim     = limit;
        rq      = 0;
        kmax    = (max_count == 0) ? 1 : max_count;
        k       = 0;
        running = 1'b1;
        // The first iteration always runs, whatever the registers say.
        while (running) begin
            yq      = fixed_product(y, y, FRAC_BITS);
            xq      = fixed_product(x, x, FRAC_BITS);
            y       = clamp_coord(fixed_product(x, y, FRAC_BITS - 1) + im);
            x       = clamp_coord(re + (xq - yq));
            rq      = clamp_coord(xq + yq);
            k       = k + 1;
            running = (rq < lim) && (k < kmax);
        end
        px.count   = k[COUNT_WIDTH-1:0];
        px.escaped = (rq >= lim);
        px.dot     = px.escaped & k[0];
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            iter_max_copy = ITER_MAX_RESET;
            limit_sq_copy = LIMIT_RESET;
            expected_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.count   = i_iteration_count;
                got.escaped = i_escaped;
                got.dot     = i_dot;
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"[%0t] result %0d with no request waiting: ",
                                  "count=%0d escaped=%b dot=%b"},
                                 $realtime, results_seen, got.count, got.escaped, got.dot);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"[%0t] result %0d: expected count=%0d escaped=%b ",
                                      "dot=%b, got count=%0d escaped=%b dot=%b"},
                                     $realtime, results_seen, want.count, want.escaped,
                                     want.dot, got.count, got.escaped, got.dot);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pixels.push_back(escape_time_of(i_c_real, i_c_imag,
                                                         iter_max_copy, limit_sq_copy));
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ITER_MAX) begin
                    iter_max_copy = i_cfg_data[COUNT_WIDTH-1:0];
                end else begin
                    limit_sq_copy = i_cfg_data;
                end
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the escape-time pixel core.
// ----------------------------------------------------------------------------
// Directed points cover the coordinate extremes, exact escape on the limit,
// bounded orbits, a zero iteration maximum, a zero limit and the full 16-bit
// count. Random phases then change both registers and send points drawn
// mostly from the interesting part of the plane, with random gaps on the
// request side in most phases and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import metp_pkg::*;

    localparam int          ONE         = 1 << FRAC_BITS;
    localparam int unsigned CYCLE_LIMIT = 8_000_000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [LIMIT_WIDTH-1:0] cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    t_coord                 c_real;
    t_coord                 c_imag;
    logic                   out_valid;
    logic                   out_stall;
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic                   escaped;
    logic                   dot;
    int                     pending;
    int                     fail_count;
    int unsigned            cycle_count = 0;
    int                     points_sent;
    int                     settings_used;
    bit                     gaps_on;

    mandelbrot_escape_time_pixel_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_c_real          (c_real),
        .i_c_imag          (c_imag),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_iteration_count (iteration_count),
        .o_escaped         (escaped),
        .o_dot             (dot)
    );

    escape_time_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_c_real          (c_real),
        .i_c_imag          (c_imag),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_iteration_count (iteration_count),
        .i_escaped         (escaped),
        .i_dot             (dot),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // Result-side stalls: free stretches, short stalls and a few long ones.
    initial begin : result_stall_driver
        int unsigned r;
        int unsigned run;
        logic        hold;
        out_stall = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                hold = 1'b0;
                run  = $urandom_range(200, 600);
            end else if (r < 60) begin
                hold = 1'b0;
                run  = $urandom_range(1, 40);
            end else if (r < 95) begin
                hold = 1'b1;
                run  = $urandom_range(1, 4);
            end else begin
                hold = 1'b1;
                run  = $urandom_range(20, 80);
            end
            repeat (run) begin
                @(negedge i_clk);
                out_stall <= hold;
            end
        end
    end

    task automatic send_point(input t_coord re, input t_coord im);
        int unsigned gap;
        gap = gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        c_real   <= re;
        c_imag   <= im;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        points_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [LIMIT_WIDTH-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_registers(input logic [COUNT_WIDTH-1:0] max_count,
                                 input logic [LIMIT_WIDTH-1:0] limit);
        wait_idle();
        write_reg(CFG_ITER_MAX, LIMIT_WIDTH'(max_count));
        write_reg(CFG_LIMIT_SQ, limit);
        settings_used++;
    endtask

    task automatic send_random_point();
        int unsigned r;
        t_coord      re;
        t_coord      im;
        t_coord      corners[5];
        corners = '{COORD_MAX, COORD_MIN, 0, -1, 1};
        r = $urandom_range(0, 99);
        if (r < 70) begin
            // Window [-2.5, 1.0] x [-1.5, 1.5] holds nearly all of the set.
            re = int'($urandom_range(0, 7 * ONE / 2)) - 5 * ONE / 2;
            im = int'($urandom_range(0, 3 * ONE)) - 3 * ONE / 2;
        end else if (r < 80) begin
            // Around the neck near -0.75, where orbits run long.
            re = -3 * ONE / 4 + int'($urandom_range(0, ONE / 10)) - ONE / 20;
            im = ONE / 10 + int'($urandom_range(0, ONE / 10)) - ONE / 20;
        end else if (r < 92) begin
            re = $urandom;
            im = $urandom;
        end else begin
            re = corners[$urandom_range(0, 4)];
            im = corners[$urandom_range(0, 4)];
        end
        send_point(re, im);
    endtask

    initial begin : stimulus
        int                     ph;
        int                     n;
        int                     items;
        logic [COUNT_WIDTH-1:0] max_count;
        logic [LIMIT_WIDTH-1:0] limit;

        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ITER_MAX;
        cfg_data      = '0;
        in_valid      = 1'b0;
        c_real        = '0;
        c_imag        = '0;
        points_sent   = 0;
        settings_used = 1;
        gaps_on       = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the reset registers.
        send_point(0, 0);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MIN, COORD_MAX);
        send_point(COORD_MAX, COORD_MIN);
        send_point(-2 * ONE, 0);            // lands exactly on the limit
        send_point(ONE / 4, 0);
        send_point(-ONE, 0);
        send_point(0, ONE);
        send_point(-3 * ONE / 4, ONE / 10);
        send_point(3 * ONE / 10, ONE / 2);
        send_point(ONE, ONE);
        send_point(-1, -1);                 // tiny products round down to zero
        send_point(1, 1);
        send_point(4 * ONE, 0);

        // A zero maximum behaves as a single iteration.
        set_registers(0, LIMIT_WIDTH'(4 * ONE));
        send_point(0, 0);
        send_point(COORD_MAX, 0);
        set_registers(1, LIMIT_WIDTH'(4 * ONE));
        send_point(COORD_MIN, 0);
        // With a zero limit everything escapes on the first pass.
        set_registers(255, 0);
        send_point(0, 0);
        send_point(-ONE, ONE / 2);
        // Full limit: only a saturated magnitude reaches it.
        set_registers(16'hFFFF, {LIMIT_WIDTH{1'b1}});
        send_point(COORD_MAX, 0);
        send_point(0, 0);                   // runs to the full count
        set_registers(16'hFFFF, LIMIT_WIDTH'(4 * ONE));
        send_point(ONE / 4 + ONE / 100, 0);

        for (ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0:       max_count = COUNT_WIDTH'($urandom_range(2, 16));
                1:       max_count = COUNT_WIDTH'($urandom_range(17, 64));
                2:       max_count = COUNT_WIDTH'($urandom_range(2, 40));
                3:       max_count = 255;
                default: max_count = COUNT_WIDTH'($urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 7))
                0:       limit = 0;
                1:       limit = {LIMIT_WIDTH{1'b1}};
                2, 3:    limit = LIMIT_WIDTH'($urandom);
                default: limit = LIMIT_WIDTH'(4 * ONE);
            endcase
            items   = (ph % 5 == 3) ? 40 : 140;
            gaps_on = (ph % 3 != 1);
            set_registers(max_count, limit);
            for (n = 0; n < items; n++) begin
                if ($urandom_range(0, 49) == 0) begin
                    wait_idle();
                end
                send_random_point();
            end
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d points under %0d register settings, from one-pass and zero-limit",
                 points_sent, settings_used);
        $display("cases up to full 16-bit counts, with random request gaps and result stalls.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
